>>> rtl/tlssni_pkg.sv
// Shared types and constants of the TLS ClientHello server-name extractor.
// Holds the parse phase codes, status codes, header offsets and beat structs.
// No dependencies; every other file of the block but tlssni_if refers to it by scoped names.
package tlssni_pkg;

    // Parse phases.
    localparam logic [3:0] PH_IDLE        = 4'd0;
    localparam logic [3:0] PH_HDR         = 4'd1;
    localparam logic [3:0] PH_SID_SKIP    = 4'd2;
    localparam logic [3:0] PH_CS_LEN      = 4'd3;
    localparam logic [3:0] PH_CS_SKIP     = 4'd4;
    localparam logic [3:0] PH_CM_LEN      = 4'd5;
    localparam logic [3:0] PH_CM_SKIP     = 4'd6;
    localparam logic [3:0] PH_EXT_BLK_LEN = 4'd7;
    localparam logic [3:0] PH_EXT_TYPE    = 4'd8;
    localparam logic [3:0] PH_EXT_LEN     = 4'd9;
    localparam logic [3:0] PH_EXT_SKIP    = 4'd10;
    localparam logic [3:0] PH_SNI_HDR     = 4'd11;
    localparam logic [3:0] PH_NAME        = 4'd12;
    localparam logic [3:0] PH_NOT_HELLO   = 4'd13;
    localparam logic [3:0] PH_NO_SNI      = 4'd14;

    // Result status codes.
    localparam logic [1:0] ST_NAME      = 2'd0;
    localparam logic [1:0] ST_NOT_HELLO = 2'd1;
    localparam logic [1:0] ST_NO_SNI    = 2'd2;
    localparam logic [1:0] ST_TRUNC     = 2'd3;

    // Record and handshake header values and offsets.
    localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [15:0] HS_TYPE_AT      = 16'd5;
    localparam logic [15:0] SID_LEN_AT      = 16'd43;
    localparam logic [15:0] SNI_HDR_START   = 16'd2;
    localparam logic [15:0] SNI_NAME_LEN_AT = 16'd7;
    localparam logic [15:0] SNI_NAME_AT     = 16'd9;
    localparam logic [15:0] POS_MAX         = 16'hFFFF;

    // Result queue size; a beat can produce two results.
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);
    localparam int OUTQ_IDX_W = $clog2(OUTQ_DEPTH);

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       first_of_segment;
        logic       last_of_segment;
    } item_t;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       name_last;
        logic [1:0] status;
    } result_t;

    // Results produced by one accepted beat, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first_res;
        result_t    second_res;
    } push_t;

endpackage

>>> rtl/tlssni_if.sv
// Valid/ready channel interfaces for the payload input and the result output.
// Field names match the beat structs of tlssni_pkg; it has no dependencies.
interface tlssni_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       first_of_segment;
    logic       last_of_segment;

    modport source (output valid, output payload_byte, output first_of_segment,
                    output last_of_segment, input ready);
    modport sink   (input valid, input payload_byte, input first_of_segment,
                    input last_of_segment, output ready);
endinterface

interface tlssni_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_byte;
    logic       name_last;
    logic [1:0] status;

    modport source (output valid, output name_byte, output name_last, output status,
                    input ready);
    modport sink   (input valid, input name_byte, input name_last, input status,
                     output ready);
endinterface

>>> rtl/tlssni_parser.sv
// Byte-wise ClientHello parser: parse state registers and their next-state logic.
// Depends on tlssni_pkg for phase codes, offsets and the beat structs.
module tlssni_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  tlssni_pkg::item_t item,
    output tlssni_pkg::push_t push
);

    logic [15:0] byte_pos_reg, byte_pos_next;
    logic [3:0]  phase_reg, phase_next;
    logic [15:0] field_rem_reg, field_rem_next;
    logic [15:0] ext_rem_reg, ext_rem_next;
    logic [7:0]  held_reg, held_next;

    logic [7:0]  b;
    logic [15:0] len16;
    logic        trunc_v;
    logic        name_v;
    logic        name_last;
    logic        end_v;
    logic [1:0]  end_st;
    tlssni_pkg::result_t trunc_res, name_res, end_res;

    assign b = item.payload_byte;

    always_comb
    begin
        phase_next     = phase_reg;
        field_rem_next = field_rem_reg;
        ext_rem_next   = ext_rem_reg;
        held_next      = held_reg;
        byte_pos_next  = byte_pos_reg;
        trunc_v        = 1'b0;
        name_v         = 1'b0;
        name_last      = 1'b0;
        end_v          = 1'b0;
        end_st         = tlssni_pkg::ST_TRUNC;

        // A segment start abandons any segment still in progress.
        if (item.first_of_segment)
        begin
            trunc_v        = (phase_reg != tlssni_pkg::PH_IDLE);
            phase_next     = tlssni_pkg::PH_HDR;
            field_rem_next = 16'd0;
            ext_rem_next   = 16'd0;
            held_next      = 8'd0;
            byte_pos_next  = 16'd0;
        end

        len16 = {held_next, b};

        if (phase_next != tlssni_pkg::PH_IDLE)
        begin
            case (phase_next)
                tlssni_pkg::PH_HDR:
                begin
                    if (byte_pos_next == 16'd0 && b != tlssni_pkg::REC_HANDSHAKE)
                    begin
                        phase_next = tlssni_pkg::PH_NOT_HELLO;
                    end
                    else if (byte_pos_next == tlssni_pkg::HS_TYPE_AT &&
                             b != tlssni_pkg::HS_CLIENT_HELLO)
                    begin
                        phase_next = tlssni_pkg::PH_NOT_HELLO;
                    end
                    else if (byte_pos_next == tlssni_pkg::SID_LEN_AT)
                    begin
                        field_rem_next = {8'd0, b};
                        phase_next = (b != 8'd0) ? tlssni_pkg::PH_SID_SKIP
                                                 : tlssni_pkg::PH_CS_LEN;
                    end
                end
                tlssni_pkg::PH_SID_SKIP:
                begin
                    field_rem_next = field_rem_next - 16'd1;
                    if (field_rem_next == 16'd0)
                    begin
                        phase_next = tlssni_pkg::PH_CS_LEN;
                    end
                end
                tlssni_pkg::PH_CS_LEN:
                begin
                    if (field_rem_next == 16'd0)
                    begin
                        held_next      = b;
                        field_rem_next = 16'd1;
                    end
                    else
                    begin
                        field_rem_next = len16;
                        phase_next = (len16 != 16'd0) ? tlssni_pkg::PH_CS_SKIP
                                                      : tlssni_pkg::PH_CM_LEN;
                    end
                end
                tlssni_pkg::PH_CS_SKIP:
                begin
                    field_rem_next = field_rem_next - 16'd1;
                    if (field_rem_next == 16'd0)
                    begin
                        phase_next = tlssni_pkg::PH_CM_LEN;
                    end
                end
                tlssni_pkg::PH_CM_LEN:
                begin
                    field_rem_next = {8'd0, b};
                    phase_next = (b != 8'd0) ? tlssni_pkg::PH_CM_SKIP
                                             : tlssni_pkg::PH_EXT_BLK_LEN;
                end
                tlssni_pkg::PH_CM_SKIP:
                begin
                    field_rem_next = field_rem_next - 16'd1;
                    if (field_rem_next == 16'd0)
                    begin
                        phase_next = tlssni_pkg::PH_EXT_BLK_LEN;
                    end
                end
                tlssni_pkg::PH_EXT_BLK_LEN:
                begin
                    if (field_rem_next == 16'd0)
                    begin
                        held_next      = b;
                        field_rem_next = 16'd1;
                    end
                    else
                    begin
                        field_rem_next = 16'd0;
                        ext_rem_next   = len16;
                        phase_next = (len16 != 16'd0) ? tlssni_pkg::PH_EXT_TYPE
                                                      : tlssni_pkg::PH_NO_SNI;
                    end
                end
                tlssni_pkg::PH_EXT_TYPE:
                begin
                    if (ext_rem_next != 16'd0)
                    begin
                        ext_rem_next = ext_rem_next - 16'd1;
                    end
                    if (field_rem_next == 16'd0)
                    begin
                        held_next      = b;
                        field_rem_next = 16'd1;
                    end
                    else if (len16 == 16'd0)
                    begin
                        phase_next     = tlssni_pkg::PH_SNI_HDR;
                        field_rem_next = tlssni_pkg::SNI_HDR_START;
                    end
                    else
                    begin
                        field_rem_next = 16'd0;
                        phase_next     = tlssni_pkg::PH_EXT_LEN;
                    end
                end
                tlssni_pkg::PH_EXT_LEN:
                begin
                    if (ext_rem_next != 16'd0)
                    begin
                        ext_rem_next = ext_rem_next - 16'd1;
                    end
                    if (field_rem_next == 16'd0)
                    begin
                        held_next      = b;
                        field_rem_next = 16'd1;
                    end
                    else
                    begin
                        field_rem_next = len16;
                        phase_next = (len16 != 16'd0) ? tlssni_pkg::PH_EXT_SKIP
                                                      : tlssni_pkg::PH_EXT_TYPE;
                    end
                end
                tlssni_pkg::PH_EXT_SKIP:
                begin
                    if (ext_rem_next != 16'd0)
                    begin
                        ext_rem_next = ext_rem_next - 16'd1;
                    end
                    field_rem_next = field_rem_next - 16'd1;
                    if (field_rem_next == 16'd0)
                    begin
                        phase_next = tlssni_pkg::PH_EXT_TYPE;
                    end
                end
                tlssni_pkg::PH_SNI_HDR:
                begin
                    // Walks the extension length, list length and name type, then reads the name length.
                    if (field_rem_next == tlssni_pkg::SNI_NAME_LEN_AT)
                    begin
                        held_next      = b;
                        field_rem_next = field_rem_next + 16'd1;
                    end
                    else if (field_rem_next == tlssni_pkg::SNI_NAME_AT - 16'd1)
                    begin
                        field_rem_next = len16;
                        phase_next = (len16 != 16'd0) ? tlssni_pkg::PH_NAME
                                                      : tlssni_pkg::PH_NO_SNI;
                    end
                    else
                    begin
                        field_rem_next = field_rem_next + 16'd1;
                    end
                end
                tlssni_pkg::PH_NAME:
                begin
                    field_rem_next = field_rem_next - 16'd1;
                    name_v = 1'b1;
                    if (field_rem_next == 16'd0)
                    begin
                        name_last  = 1'b1;
                        phase_next = tlssni_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                end
            endcase

            // The extension walk is bounded by the extension block.
            if ((phase_next == tlssni_pkg::PH_EXT_TYPE ||
                 phase_next == tlssni_pkg::PH_EXT_LEN ||
                 phase_next == tlssni_pkg::PH_EXT_SKIP) && ext_rem_next == 16'd0)
            begin
                phase_next = tlssni_pkg::PH_NO_SNI;
            end

            if (byte_pos_next != tlssni_pkg::POS_MAX)
            begin
                byte_pos_next = byte_pos_next + 16'd1;
            end

            if (item.last_of_segment && phase_next != tlssni_pkg::PH_IDLE)
            begin
                end_v = 1'b1;
                if (phase_next == tlssni_pkg::PH_NOT_HELLO)
                begin
                    end_st = tlssni_pkg::ST_NOT_HELLO;
                end
                else if (phase_next == tlssni_pkg::PH_NO_SNI)
                begin
                    end_st = tlssni_pkg::ST_NO_SNI;
                end
                else if (phase_next == tlssni_pkg::PH_EXT_BLK_LEN &&
                         field_rem_next == 16'd0)
                begin
                    end_st = tlssni_pkg::ST_NO_SNI;
                end
                phase_next = tlssni_pkg::PH_IDLE;
            end
        end
    end

    assign trunc_res = '{name_byte: 8'd0, name_last: 1'b0, status: tlssni_pkg::ST_TRUNC};
    assign name_res  = '{name_byte: b, name_last: name_last, status: tlssni_pkg::ST_NAME};
    assign end_res   = '{name_byte: 8'd0, name_last: 1'b0, status: end_st};

    // A start abort never coincides with a name byte, so at most two results exist.
    always_comb
    begin
        push.first_res  = trunc_v ? trunc_res : (name_v ? name_res : end_res);
        push.second_res = end_res;
        if (!fire)
        begin
            push.count = 2'd0;
        end
        else
        begin
            push.count = 2'({1'b0, trunc_v}) + 2'({1'b0, name_v}) + 2'({1'b0, end_v});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg  <= 16'd0;
            phase_reg     <= tlssni_pkg::PH_IDLE;
            field_rem_reg <= 16'd0;
            ext_rem_reg   <= 16'd0;
            held_reg      <= 8'd0;
        end
        else if (fire)
        begin
            byte_pos_reg  <= byte_pos_next;
            phase_reg     <= phase_next;
            field_rem_reg <= field_rem_next;
            ext_rem_reg   <= ext_rem_next;
            held_reg      <= held_next;
        end
    end

    a_results_need_beat: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> fire)
        else $error("parser produced results without an accepted beat");

    a_restart_truncates: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.first_of_segment && phase_reg != tlssni_pkg::PH_IDLE |->
        push.count != 2'd0 && push.first_res.status == tlssni_pkg::ST_TRUNC)
        else $error("abandoned segment did not report truncation");

    a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.last_of_segment |=> phase_reg == tlssni_pkg::PH_IDLE)
        else $error("parser not idle after the last beat of a segment");

endmodule

>>> rtl/tlssni_outq.sv
// Result queue: fixed-position shift register of results with a fill count.
// Takes up to two results per cycle, delivers one. Depends on tlssni_pkg.
module tlssni_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  tlssni_pkg::push_t   push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output tlssni_pkg::result_t head
);

    localparam int Depth = tlssni_pkg::OUTQ_DEPTH;
    localparam int CntW  = tlssni_pkg::OUTQ_CNT_W;

    tlssni_pkg::result_t slot_reg  [Depth];
    tlssni_pkg::result_t slot_next [Depth];
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [CntW-1:0] base;
    logic            pop;

    assign out_valid = (cnt_reg != '0);
    assign head      = slot_reg[0];
    assign pop       = out_valid && out_ready;
    assign room      = (cnt_reg <= CntW'(Depth - 2));
    assign base      = cnt_reg - CntW'(pop);
    assign cnt_next  = base + CntW'(push.count);

    always_comb
    begin
        for (int i = 0; i < Depth; i++)
        begin
            if (pop && i < Depth - 1)
            begin
                slot_next[i] = slot_reg[(i + 1) % Depth];
            end
            else
            begin
                slot_next[i] = slot_reg[i];
            end
            if (push.count != 2'd0 && CntW'(i) == base)
            begin
                slot_next[i] = push.first_res;
            end
            if (push.count == 2'd2 && CntW'(i) == base + CntW'(1))
            begin
                slot_next[i] = push.second_res;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Depth; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntW'(Depth))
        else $error("result queue count beyond its depth");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> room)
        else $error("results pushed into a queue without room for two");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push.count == 2'd0 |=> cnt_reg == $past(cnt_reg) - CntW'(1))
        else $error("delivered result did not leave the queue");

endmodule

>>> rtl/tls_client_hello_sni_extractor_core.sv
// Top level of the TLS ClientHello server-name extractor.
// Depends on tlssni_pkg, tlssni_if, tlssni_parser and tlssni_outq.
//
// The block takes one TCP payload byte per beat, one beat per clock cycle while
// ready is high, and finds the server_name extension of a TLS ClientHello. The
// record type (byte 0) and handshake type (byte 5) are checked, the random is
// skipped by its fixed offset, the session id, cipher suites and compression
// methods by their own length fields, and the extension block is walked within
// its declared length. Each host name byte comes out as a status 0 beat, the
// last one marked by name_last; after that the rest of the segment is ignored.
// A segment that ends without a full name gives one status beat: 1 when it is
// not a ClientHello, 2 when there is no server name, 3 when it was cut short. A
// first_of_segment beat arriving while a segment is still open first reports
// status 3 for the old segment. Every accepted byte is parsed in the cycle it is
// accepted, and its results are registered into a four-entry result queue behind
// any results still waiting; since one byte can produce two results, the input
// is ready whenever at most two results are waiting, so with the output taking
// one beat per cycle the input sustains one byte per cycle. When the output
// stalls, input ready drops once three results are queued.
module tls_client_hello_sni_extractor_core (
    input  logic         clk,
    input  logic         rst_n,
    tlssni_in_if.sink    payload,
    tlssni_out_if.source result
);

    tlssni_pkg::item_t   item;
    tlssni_pkg::push_t   push;
    tlssni_pkg::result_t head;
    logic                room;
    logic                fire;

    // The input is ready exactly when the queue can hold a full pair of results.
    assign payload.ready = room;
    assign fire          = payload.valid && room;

    assign item.payload_byte     = payload.payload_byte;
    assign item.first_of_segment = payload.first_of_segment;
    assign item.last_of_segment  = payload.last_of_segment;

    tlssni_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .push  (push)
    );

    tlssni_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .head      (head)
    );

    assign result.name_byte = head.name_byte;
    assign result.name_last = head.name_last;
    assign result.status    = head.status;

endmodule
